// ===== rtl/core/gas_level_alarm_with_beep_burst_top_assert.svh =====
// assertion macros for the gas level alarm block
`ifndef GAS_LEVEL_ALARM_WITH_BEEP_BURST_TOP_ASSERT_SVH
`define GAS_LEVEL_ALARM_WITH_BEEP_BURST_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GLA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define GLA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/gla_pkg.sv =====
// types and constants shared by the gas level alarm modules
package gla_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 16;
   localparam int RSP_W     = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GAS_THRESHOLD    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DANGER_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_THRESHOLD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_INTERVAL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_INTERVAL    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BEEPS_PER_BURST  = 3'd5;

   localparam logic [9:0]  GAS_THRESHOLD_RST    = 10'd100;
   localparam logic [9:0]  DANGER_THRESHOLD_RST = 10'd400;
   localparam logic [9:0]  RISE_THRESHOLD_RST   = 10'd7;
   localparam logic [15:0] SLOW_INTERVAL_RST    = 16'd400;
   localparam logic [15:0] FAST_INTERVAL_RST    = 16'd200;
   localparam logic [2:0]  BEEPS_PER_BURST_RST  = 3'd4;

   typedef enum logic [1:0] {
      LEVEL_SAFE     = 2'd0,
      LEVEL_MODERATE = 2'd1,
      LEVEL_DANGER   = 2'd2
   } level_type;

   typedef struct packed {
      logic [9:0]  gas_threshold;
      logic [9:0]  danger_threshold;
      logic [9:0]  rise_threshold;
      logic [15:0] slow_interval_ms;
      logic [15:0] fast_interval_ms;
      logic [2:0]  beeps_per_burst;
   } cfg_type;

   // packed msb first, so gas_level lands in the lowest bits
   typedef struct packed {
      logic               burst_running;
      logic               buzzer_on;
      logic signed [10:0] rise;
      logic               gas_detected;
      level_type          gas_level;
   } rsp_type;

endpackage

// ===== rtl/core/gla_csr.sv =====
// configuration register bank
module gla_csr
   import gla_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gas_threshold    <= GAS_THRESHOLD_RST;
         cfg_ff.danger_threshold <= DANGER_THRESHOLD_RST;
         cfg_ff.rise_threshold   <= RISE_THRESHOLD_RST;
         cfg_ff.slow_interval_ms <= SLOW_INTERVAL_RST;
         cfg_ff.fast_interval_ms <= FAST_INTERVAL_RST;
         cfg_ff.beeps_per_burst  <= BEEPS_PER_BURST_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GAS_THRESHOLD:    cfg_ff.gas_threshold    <= csr_wdata[9:0];
            CSR_DANGER_THRESHOLD: cfg_ff.danger_threshold <= csr_wdata[9:0];
            CSR_RISE_THRESHOLD:   cfg_ff.rise_threshold   <= csr_wdata[9:0];
            CSR_SLOW_INTERVAL:    cfg_ff.slow_interval_ms <= csr_wdata[15:0];
            CSR_FAST_INTERVAL:    cfg_ff.fast_interval_ms <= csr_wdata[15:0];
            CSR_BEEPS_PER_BURST:  cfg_ff.beeps_per_burst  <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/gla_in_reg.sv =====
// input register stage for sensor requests
module gla_in_reg
   import gla_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [SAMPLE_BITS-1:0] in_sample,
   input  logic [31:0]            in_now_ms,
   input  logic                   advance,
   output logic                   in_ready,
   output logic                   hold_valid,
   output logic [SAMPLE_BITS-1:0] hold_sample,
   output logic [31:0]            hold_now_ms
);

   logic                   valid_ff;
   logic                   valid_in;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [31:0]            now_ms_ff;

   assign in_ready = !valid_ff || advance;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         sample_ff <= in_sample;
         now_ms_ff <= in_now_ms;
      end
   end

   assign hold_valid  = valid_ff;
   assign hold_sample = sample_ff;
   assign hold_now_ms = now_ms_ff;

endmodule

// ===== rtl/core/gla_step.sv =====
// detection, level and beep burst state update for one request
module gla_step
   import gla_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [31:0]            now_ms,
   input  cfg_type                cfg,
   output rsp_type                rsp
);

   localparam int DW = (SAMPLE_BITS + 1 > 11) ? SAMPLE_BITS + 1 : 11;

   logic [SAMPLE_BITS-1:0] prev_sample_ff;
   logic [31:0]            last_toggle_ff;
   logic [31:0]            last_toggle_in;
   logic                   buzzer_ff;
   logic                   buzzer_in;
   logic [2:0]             beep_count_ff;
   logic [2:0]             beep_count_in;
   logic                   burst_active_ff;
   logic                   burst_active_in;
   logic                   burst_slow_ff;
   logic                   burst_slow_in;

   logic [DW-1:0]          sample_ext;
   logic [DW-1:0]          prev_ext;
   logic signed [DW-1:0]   diff;
   logic [DW-1:0]          gas_thr_ext;
   logic [DW-1:0]          danger_ext;
   logic signed [DW-1:0]   rise_thr_ext;
   logic                   gas;
   level_type              level;
   logic                   start;
   logic                   buzzer_a;
   logic [2:0]             count_a;
   logic [31:0]            last_a;
   logic [15:0]            interval;
   logic [31:0]            elapsed;

   always_comb begin
      sample_ext   = {{(DW - SAMPLE_BITS){1'b0}}, sample};
      prev_ext     = {{(DW - SAMPLE_BITS){1'b0}}, prev_sample_ff};
      diff         = $signed(sample_ext - prev_ext);
      gas_thr_ext  = {{(DW - 10){1'b0}}, cfg.gas_threshold};
      danger_ext   = {{(DW - 10){1'b0}}, cfg.danger_threshold};
      rise_thr_ext = $signed({{(DW - 10){1'b0}}, cfg.rise_threshold});
      gas          = (sample_ext >= gas_thr_ext) || (diff > rise_thr_ext);

      if (!gas) begin
         level = LEVEL_SAFE;
      end else if (sample_ext > danger_ext) begin
         level = LEVEL_DANGER;
      end else begin
         level = LEVEL_MODERATE;
      end

      // burst start takes effect before the buzzer update
      start         = gas && !burst_active_ff;
      burst_slow_in = start ? (level == LEVEL_MODERATE) : burst_slow_ff;
      buzzer_a      = start ? 1'b0 : buzzer_ff;
      count_a       = start ? 3'd0 : beep_count_ff;
      last_a        = start ? now_ms : last_toggle_ff;

      interval = burst_slow_in ? cfg.slow_interval_ms : cfg.fast_interval_ms;
      elapsed  = now_ms - last_a;

      last_toggle_in  = last_a;
      buzzer_in       = buzzer_a;
      beep_count_in   = count_a;
      burst_active_in = 1'b1;
      if ((burst_active_ff || gas) && (count_a < cfg.beeps_per_burst)) begin
         if (elapsed >= {16'd0, interval}) begin
            last_toggle_in = now_ms;
            buzzer_in      = !buzzer_a;
            if (buzzer_a) begin
               beep_count_in = count_a + 3'd1;
            end
         end
      end else begin
         burst_active_in = 1'b0;
         beep_count_in   = 3'd0;
         buzzer_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sample_ff  <= '0;
         last_toggle_ff  <= '0;
         buzzer_ff       <= 1'b0;
         beep_count_ff   <= '0;
         burst_active_ff <= 1'b0;
         burst_slow_ff   <= 1'b0;
      end else if (fire) begin
         prev_sample_ff  <= sample;
         last_toggle_ff  <= last_toggle_in;
         buzzer_ff       <= buzzer_in;
         beep_count_ff   <= beep_count_in;
         burst_active_ff <= burst_active_in;
         burst_slow_ff   <= burst_slow_in;
      end
   end

   always_comb begin
      rsp.gas_level     = level;
      rsp.gas_detected  = gas;
      rsp.rise          = diff[10:0];
      rsp.buzzer_on     = buzzer_in;
      rsp.burst_running = burst_active_in;
   end

endmodule

// ===== rtl/core/gas_level_alarm_with_beep_burst_top.sv =====
// top level of the gas level alarm with beep burst
// Takes one sensor request per cycle (sample and millisecond time) while the result side
// is ready, and returns one result per request, held first in the input register and
// then in the result register. Throughput is one request per cycle unless the result
// side stalls, set by the combinational update of the detection and burst state
// between those registers. A stalled result still lets one more request be held.
// Configuration writes go straight to the register bank and must be made while no
// request is in flight.
`include "gas_level_alarm_with_beep_burst_top_assert.svh"

module gas_level_alarm_with_beep_burst_top
   import gla_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // sample [SAMPLE_BITS-1:0], now_ms next 32 bits, zero padded to bytes
   input  logic [((SAMPLE_BITS + 32 + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // gas_level [1:0], gas_detected [2], rise [13:3], buzzer_on [14], burst_running [15]
   output logic [RSP_W-1:0]     rsp_tdata,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   cfg_type                cfg;
   logic                   advance;
   logic                   hold_valid;
   logic [SAMPLE_BITS-1:0] hold_sample;
   logic [31:0]            hold_now_ms;
   logic                   fire;
   rsp_type                step_rsp;
   rsp_type                rsp_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;

   gla_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gla_in_reg #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_sample   (req_tdata[SAMPLE_BITS-1:0]),
      .in_now_ms   (req_tdata[SAMPLE_BITS+31:SAMPLE_BITS]),
      .advance     (advance),
      .in_ready    (req_tready),
      .hold_valid  (hold_valid),
      .hold_sample (hold_sample),
      .hold_now_ms (hold_now_ms)
   );

   gla_step #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_step (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .sample (hold_sample),
      .now_ms (hold_now_ms),
      .cfg    (cfg),
      .rsp    (step_rsp)
   );

   assign advance      = !rsp_valid_ff || rsp_tready;
   assign fire         = hold_valid && advance;
   assign rsp_valid_in = advance ? hold_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // buzzer only sounds inside a running burst
   `GLA_ASSERT_NOW(a_buzzer_in_burst, rsp_valid_ff && rsp_ff.buzzer_on, rsp_ff.burst_running, "buzzer on outside burst")

   // no detection means safe level
   `GLA_ASSERT_NOW(a_safe_without_gas, rsp_valid_ff && !rsp_ff.gas_detected, rsp_ff.gas_level == LEVEL_SAFE, "level set without detection")

   // a held request survives a stalled result
   `GLA_ASSERT_NEXT(a_hold_on_stall, hold_valid && !advance, hold_valid, "held request lost on stall")

   // a fired request always shows up as a result
   `GLA_ASSERT_NEXT(a_fire_to_rsp, fire, rsp_valid_ff, "request fired without result")

endmodule

// ===== bench/tb_gas_level_alarm_with_beep_burst_top.sv =====
// testbench for the gas level alarm with beep burst against a predictor
`timescale 1ns / 1ps

module tb_gas_level_alarm_with_beep_burst_top
   import gla_pkg::*;
();

   localparam int REQ_W = ((10 + 32 + 7) / 8) * 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int DIRECTED_N = 20;
   localparam int PHASE_ITEMS = 275;

   class alarm_scoreboard;
      cfg_type     cfg;
      logic [9:0]  prev_sample;
      logic [31:0] last_toggle;
      bit          buzzer;
      bit          burst;
      bit          slow_burst;
      logic [2:0]  beeps_done;
      rsp_type     expected_q[$];
      int          mismatches;
      int          failures;

      function new();
         cfg.gas_threshold    = GAS_THRESHOLD_RST;
         cfg.danger_threshold = DANGER_THRESHOLD_RST;
         cfg.rise_threshold   = RISE_THRESHOLD_RST;
         cfg.slow_interval_ms = SLOW_INTERVAL_RST;
         cfg.fast_interval_ms = FAST_INTERVAL_RST;
         cfg.beeps_per_burst  = BEEPS_PER_BURST_RST;
         prev_sample = '0;
         last_toggle = '0;
         buzzer      = 1'b0;
         burst       = 1'b0;
         slow_burst  = 1'b0;
         beeps_done  = '0;
         mismatches  = 0;
         failures    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            CSR_GAS_THRESHOLD:    cfg.gas_threshold    = val[9:0];
            CSR_DANGER_THRESHOLD: cfg.danger_threshold = val[9:0];
            CSR_RISE_THRESHOLD:   cfg.rise_threshold   = val[9:0];
            CSR_SLOW_INTERVAL:    cfg.slow_interval_ms = val[15:0];
            CSR_FAST_INTERVAL:    cfg.fast_interval_ms = val[15:0];
            CSR_BEEPS_PER_BURST:  cfg.beeps_per_burst  = val[2:0];
            default: ;
         endcase
      endfunction

      function void note_request(logic [9:0] smp, logic [31:0] now);
         int          diff;
         bit          gas;
         level_type   lvl;
         logic [15:0] interval;
         logic [31:0] elapsed;
         rsp_type     r;
         diff = int'(smp) - int'(prev_sample);
         gas  = (smp >= cfg.gas_threshold) || (diff > int'(cfg.rise_threshold));
         lvl  = LEVEL_SAFE;
         if (gas) begin
            lvl = (smp > cfg.danger_threshold) ? LEVEL_DANGER : LEVEL_MODERATE;
            if (!burst) begin
               burst       = 1'b1;
               slow_burst  = (lvl == LEVEL_MODERATE);
               beeps_done  = '0;
               buzzer      = 1'b0;
               last_toggle = now;
            end
         end
         prev_sample = smp;
         interval = slow_burst ? cfg.slow_interval_ms : cfg.fast_interval_ms;
         if (burst && beeps_done < cfg.beeps_per_burst) begin
            elapsed = now - last_toggle;
            if (elapsed >= {16'b0, interval}) begin
               last_toggle = now;
               buzzer      = !buzzer;
               if (!buzzer)
                  beeps_done = beeps_done + 3'd1;
            end
         end else begin
            burst      = 1'b0;
            beeps_done = '0;
            buzzer     = 1'b0;
         end
         r.gas_level     = lvl;
         r.gas_detected  = gas;
         r.rise          = 11'(diff);
         r.buzzer_on     = buzzer;
         r.burst_running = burst;
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [RSP_W-1:0] data);
         rsp_type got;
         rsp_type want;
         got = rsp_type'(data);
         if (expected_q.size() == 0) begin
            failures++;
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with no request pending: %h", $time, data);
            return;
         end
         want = expected_q.pop_front();
         if (got.gas_level !== want.gas_level || got.gas_detected !== want.gas_detected ||
             got.rise !== want.rise || got.buzzer_on !== want.buzzer_on ||
             got.burst_running !== want.burst_running) begin
            failures++;
            mismatches++;
            if (mismatches <= 10)
               $display(
                  "%0t: exp/act lvl %0d/%0d gas %0b/%0b rise %0d/%0d buz %0b/%0b run %0b/%0b",
                  $time, want.gas_level, got.gas_level, want.gas_detected, got.gas_detected,
                  want.rise, got.rise, want.buzzer_on, got.buzzer_on,
                  want.burst_running, got.burst_running);
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   alarm_scoreboard board;
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   logic [9:0]      last_sample = '0;
   logic [31:0]     cur_time = '0;

   // thresholds, rises, a burst with detection during it, negative rise, time wrap
   logic [9:0]  dir_sample[DIRECTED_N] = '{10'd0, 10'd8, 10'd15, 10'd1023, 10'd0, 10'd99,
      10'd100, 10'd400, 10'd401, 10'd0, 10'd50, 10'd57, 10'd0, 10'd0, 10'd0, 10'd500,
      10'd500, 10'd600, 10'd1023, 10'd0};
   logic [31:0] dir_now[DIRECTED_N] = '{32'd0, 32'd10, 32'd20, 32'd420, 32'd830, 32'd831,
      32'd1240, 32'd1650, 32'd2060, 32'd2470, 32'd2900, 32'd2901, 32'd3400, 32'd3800,
      32'd4200, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h0000_0010, 32'h0000_0150, 32'hFFFF_FFFF};

   always #1 clock = ~clock;

   gas_level_alarm_with_beep_burst_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   task automatic send_request(input logic [9:0] smp, input logic [31:0] now);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, now, smp};
      do @(posedge clock); while (!req_tready);
      board.note_request(smp, now);
   endtask

   task automatic wait_results();
      req_tvalid <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [9:0] gas_thr, input logic [9:0] danger_thr,
                                input logic [9:0] rise_thr, input logic [15:0] slow_iv,
                                input logic [15:0] fast_iv, input logic [2:0] beeps);
      logic [CSR_IDX_W-1:0] idx[8];
      logic [CSR_W-1:0]     val[8];
      int                   k;
      // unused indexes and junk in the upper bits must be ignored
      idx = '{CSR_SPARE_LO, CSR_GAS_THRESHOLD, CSR_DANGER_THRESHOLD, CSR_RISE_THRESHOLD,
              CSR_SLOW_INTERVAL, CSR_FAST_INTERVAL, CSR_BEEPS_PER_BURST, CSR_SPARE_HI};
      val = '{16'($urandom), {6'($urandom), gas_thr}, {6'($urandom), danger_thr},
              {6'($urandom), rise_thr}, slow_iv, fast_iv, {13'($urandom), beeps},
              16'($urandom)};
      repeat (4) @(posedge clock);
      for (k = 0; k < 8; k++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         @(posedge clock);
         board.write_reg(idx[k], val[k]);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [9:0] pick_sample(input logic [9:0] prev);
      int pick;
      int v;
      int lo;
      int hi;
      int rs;
      pick = $urandom_range(0, 99);
      lo = board.cfg.gas_threshold;
      hi = board.cfg.danger_threshold;
      rs = board.cfg.rise_threshold;
      if (pick < 40)
         v = int'(prev) - int'($urandom_range(0, 6));
      else if (pick < 60)
         v = $urandom_range(hi, lo);
      else if (pick < 75)
         v = $urandom_range(1023, hi);
      else if (pick < 88) begin
         case ($urandom_range(0, 5))
            0: v = lo - 1;
            1: v = lo;
            2: v = hi;
            3: v = hi + 1;
            4: v = int'(prev) + rs;
            default: v = int'(prev) + rs + 1;
         endcase
      end else
         v = $urandom_range(0, 1023);
      if (v < 0)
         v = 0;
      if (v > 1023)
         v = 1023;
      return v[9:0];
   endfunction

   function automatic logic [31:0] pick_step();
      int pick;
      int fast_iv;
      int slow_iv;
      pick = $urandom_range(0, 99);
      fast_iv = board.cfg.fast_interval_ms;
      slow_iv = board.cfg.slow_interval_ms;
      if (pick < 35)
         return $urandom_range(0, fast_iv + 1);
      else if (pick < 70)
         return $urandom_range(0, slow_iv + 1);
      else if (pick < 88)
         return $urandom_range(0, 3);
      else if (pick < 96)
         return $urandom_range(0, 2 * (fast_iv + slow_iv) + 2);
      return $urandom;
   endfunction

   task automatic run_phase(input int count, input bit calm);
      int         n;
      logic [9:0] smp;
      if ($urandom_range(0, 2) == 0)
         cur_time = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      for (n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            send_idle_pct = calm ? 0 : 15 * $urandom_range(0, 2);
            stall_pct     = calm ? 0 : 15 * $urandom_range(0, 2);
         end
         smp = pick_sample(last_sample);
         cur_time = cur_time + pick_step();
         send_request(smp, cur_time);
         last_sample = smp;
      end
      wait_results();
   endtask

   // result side with random stall bursts
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #1_000_000;
      $display("tb_gas_level_alarm_with_beep_burst_top: FAIL");
      $finish;
   end

   initial begin
      int i;
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 15;
      stall_pct     = 15;
      for (i = 0; i < DIRECTED_N; i++)
         send_request(dir_sample[i], dir_now[i]);
      last_sample = dir_sample[DIRECTED_N-1];
      cur_time    = dir_now[DIRECTED_N-1];
      wait_results();

      run_phase(PHASE_ITEMS, 1'b0);
      apply_setting(10'd1023, 10'd1023, 10'd1023, 16'd1, 16'd65535, 3'd7);
      run_phase(PHASE_ITEMS, 1'b0);
      apply_setting(10'd0, 10'd0, 10'd0, 16'd0, 16'd0, 3'd0);
      run_phase(PHASE_ITEMS, 1'b0);
      apply_setting(10'd300, 10'd700, 10'd50, 16'd30, 16'd10, 3'd7);
      run_phase(PHASE_ITEMS, 1'b0);
      apply_setting(10'd512, 10'd200, 10'd1, 16'd65535, 16'd1, 3'd1);
      run_phase(PHASE_ITEMS, 1'b0);
      apply_setting(10'($urandom), 10'($urandom), 10'($urandom_range(0, 60)),
                    16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                    3'($urandom));
      run_phase(PHASE_ITEMS, 1'b0);
      apply_setting(10'd200, 10'd600, 10'd20, 16'd20, 16'd5, 3'd3);
      run_phase(PHASE_ITEMS, 1'b1);

      repeat (8) @(posedge clock);
      if (board.expected_q.size() != 0)
         board.failures++;
      if (board.failures == 0)
         $display("tb_gas_level_alarm_with_beep_burst_top: PASS");
      else
         $display("tb_gas_level_alarm_with_beep_burst_top: FAIL");
      $finish;
   end

endmodule
